>>> rtl/rgbhsv_pkg.sv
// types and constants for the rgb to hsv hue classifier
`default_nettype none

package rgbhsv_pkg;

	// channel and result widths
	localparam int CH_W   = 8;
	localparam int HUE_W  = 12;
	localparam int PCT_W  = 10;
	localparam int CLS_W  = 4;

	// stream word widths
	localparam int S_DATA_W = 3 * CH_W;
	localparam int M_FIELD_W = HUE_W + 3 * PCT_W;
	localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W  = M_DATA_W - M_FIELD_W;
	localparam int M_USER_W = 1 + CLS_W;

	// pipeline shape: front, prep, one stage per quotient bit, hue, class
	localparam int DIV_BITS = 10;
	localparam int NST      = DIV_BITS + 4;

	// internal numerator widths
	localparam int HNUM_W  = 18;
	localparam int SNUM_W  = 19;
	localparam int SDEN_W  = CH_W + 1;
	localparam int VNUM_W  = 18;
	localparam int VPROD_W = VNUM_W + 9;

	// arithmetic constants
	localparam int HUE_SECT  = 600;
	localparam int SAT_SCALE = 2000;
	localparam int VAL_SCALE = 1000;
	localparam int VAL_BIAS  = 127;
	localparam int CH_MAX    = 255;
	localparam int RECIP_255 = 257;
	localparam int RECIP_SH  = 16;

	localparam logic [HUE_W-1:0] HUE_GREEN = 12'd1200;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 12'd2400;
	localparam logic [HUE_W-1:0] HUE_FULL  = 12'd3600;
	localparam logic [HUE_W-1:0] HUE_MAX   = 12'd3599;
	localparam logic [PCT_W-1:0] PCT_MAX   = 10'd1000;

	// band starts in tenths of a degree
	localparam logic [HUE_W-1:0] BAND_ORANGE   = 12'd75;
	localparam logic [HUE_W-1:0] BAND_YELLOW   = 12'd375;
	localparam logic [HUE_W-1:0] BAND_LIME     = 12'd675;
	localparam logic [HUE_W-1:0] BAND_GREEN    = 12'd975;
	localparam logic [HUE_W-1:0] BAND_SPRING   = 12'd1275;
	localparam logic [HUE_W-1:0] BAND_CYAN     = 12'd1575;
	localparam logic [HUE_W-1:0] BAND_AZURE    = 12'd1875;
	localparam logic [HUE_W-1:0] BAND_BLUE     = 12'd2175;
	localparam logic [HUE_W-1:0] BAND_VIOLET   = 12'd2475;
	localparam logic [HUE_W-1:0] BAND_MAGENTA  = 12'd3075;
	localparam logic [HUE_W-1:0] BAND_PINKRED  = 12'd3375;
	localparam logic [HUE_W-1:0] BAND_RED_WRAP = 12'd3525;

	// hue class codes
	localparam logic [CLS_W-1:0] CLS_GREY     = 4'd0;
	localparam logic [CLS_W-1:0] CLS_RED      = 4'd1;
	localparam logic [CLS_W-1:0] CLS_ORANGE   = 4'd2;
	localparam logic [CLS_W-1:0] CLS_YELLOW   = 4'd3;
	localparam logic [CLS_W-1:0] CLS_LIME     = 4'd4;
	localparam logic [CLS_W-1:0] CLS_GREEN    = 4'd5;
	localparam logic [CLS_W-1:0] CLS_SPRING   = 4'd6;
	localparam logic [CLS_W-1:0] CLS_CYAN     = 4'd7;
	localparam logic [CLS_W-1:0] CLS_AZURE    = 4'd8;
	localparam logic [CLS_W-1:0] CLS_BLUE     = 4'd9;
	localparam logic [CLS_W-1:0] CLS_VIOLET   = 4'd10;
	localparam logic [CLS_W-1:0] CLS_MAGENTA  = 4'd11;
	localparam logic [CLS_W-1:0] CLS_PINKRED  = 4'd12;

	// everything one pixel carries down the pipeline
	typedef struct packed {
		logic [CH_W-1:0]    mx;
		logic [CH_W-1:0]    c;
		logic               grey;
		logic               neg;
		logic [HUE_W-1:0]   base;
		logic [CH_W-1:0]    dmag;
		logic [HNUM_W-1:0]  hrem;
		logic [DIV_BITS-1:0] hq;
		logic [SNUM_W-1:0]  srem;
		logic [SDEN_W-1:0]  sden;
		logic [DIV_BITS-1:0] sq;
		logic [VNUM_W-1:0]  vm;
		logic [PCT_W-1:0]   vq;
		logic [VNUM_W-1:0]  cm;
		logic [PCT_W-1:0]   cq;
		logic [HUE_W-1:0]   hue;
		logic [CLS_W-1:0]   cls;
	} pix_t;

endpackage

`default_nettype wire

>>> rtl/rgb_to_hsv_hue_classifier_unit.sv
// rgb to hsv converter with hue band classifier, fully pipelined
`default_nettype none

// Takes one 8-bit RGB pixel per clock, as long as the output side keeps up,
// and returns hue in tenths of a degree, saturation, value and chroma in
// tenths of a percent, a grey flag and a hue band (0 for grey, 1..12 for the
// twelve color bands). The pipeline is 14 stages deep. The depth is set by
// the restoring divider for hue and saturation, which resolves one quotient
// bit per stage over ten stages. Each stage holds its word until the next
// stage can take it, so bubbles close up and a stall on the output loses
// nothing.
module rgb_to_hsv_hue_classifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// red_in, green_in, blue_in
	input  logic [rgbhsv_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hue_tenths, saturation_tenths, value_tenths, chroma_tenths, zero pad
	output logic [rgbhsv_pkg::M_DATA_W-1:0]   m_tdata,
	// is_grey, hue_class
	output logic [rgbhsv_pkg::M_USER_W-1:0]   m_tuser
);

	import rgbhsv_pkg::*;

	// sort channels, pick the hexcone sector and the signed difference
	function automatic pix_t front_fn(input logic [S_DATA_W-1:0] d);
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] mxv;
		logic [CH_W-1:0] mnv;
		pix_t p;
		r = d[CH_W-1:0];
		g = d[2*CH_W-1:CH_W];
		b = d[3*CH_W-1:2*CH_W];
		p = '0;
		if (r >= g && r >= b) begin
			mxv = r;
			p.neg = (g < b);
			p.dmag = (g < b) ? b - g : g - b;
			p.base = (g < b) ? HUE_FULL : '0;
		end else if (g >= b) begin
			mxv = g;
			p.neg = (b < r);
			p.dmag = (b < r) ? r - b : b - r;
			p.base = HUE_GREEN;
		end else begin
			mxv = b;
			p.neg = (r < g);
			p.dmag = (r < g) ? g - r : r - g;
			p.base = HUE_BLUE;
		end
		mnv = r;
		if (g < mnv) mnv = g;
		if (b < mnv) mnv = b;
		p.mx = mxv;
		p.c = mxv - mnv;
		p.grey = (r == g) && (g == b);
		return p;
	endfunction

	// numerators; the negative sector rounds up so the hue floors
	function automatic pix_t prep_fn(input pix_t p);
		pix_t o;
		o = p;
		o.hrem = HNUM_W'(p.dmag) * HNUM_W'(HUE_SECT) +
			(p.neg ? HNUM_W'(p.c) - HNUM_W'(1) : '0);
		o.hq = '0;
		o.srem = SNUM_W'(p.c) * SNUM_W'(SAT_SCALE) + SNUM_W'(p.mx);
		o.sden = {p.mx, 1'b0};
		o.sq = '0;
		o.vm = VNUM_W'(p.mx) * VNUM_W'(VAL_SCALE) + VNUM_W'(VAL_BIAS);
		o.cm = VNUM_W'(p.c) * VNUM_W'(VAL_SCALE) + VNUM_W'(VAL_BIAS);
		return o;
	endfunction

	// one restoring step for both dividers
	function automatic pix_t div_step_fn(input pix_t p, input int unsigned bp);
		logic [HNUM_W-1:0] hd;
		logic [SNUM_W-1:0] sd;
		pix_t o;
		o = p;
		hd = HNUM_W'(p.c) << bp;
		sd = SNUM_W'(p.sden) << bp;
		if (p.hrem >= hd) begin
			o.hrem = p.hrem - hd;
			o.hq[bp] = 1'b1;
		end
		if (p.srem >= sd) begin
			o.srem = p.srem - sd;
			o.sq[bp] = 1'b1;
		end
		return o;
	endfunction

	// divide by 255 through the reciprocal, may come out one low
	function automatic pix_t recip_fn(input pix_t p);
		logic [VPROD_W-1:0] pv;
		logic [VPROD_W-1:0] pc;
		pix_t o;
		o = p;
		pv = VPROD_W'(p.vm) * VPROD_W'(RECIP_255);
		pc = VPROD_W'(p.cm) * VPROD_W'(RECIP_255);
		o.vq = PCT_W'(pv >> RECIP_SH);
		o.cq = PCT_W'(pc >> RECIP_SH);
		return o;
	endfunction

	function automatic pix_t recip_fix_fn(input pix_t p);
		logic [VNUM_W-1:0] rv;
		logic [VNUM_W-1:0] rc;
		pix_t o;
		o = p;
		rv = p.vm - VNUM_W'(p.vq) * VNUM_W'(CH_MAX);
		rc = p.cm - VNUM_W'(p.cq) * VNUM_W'(CH_MAX);
		if (rv >= VNUM_W'(CH_MAX)) o.vq = p.vq + PCT_W'(1);
		if (rc >= VNUM_W'(CH_MAX)) o.cq = p.cq + PCT_W'(1);
		return o;
	endfunction

	function automatic pix_t hue_fn(input pix_t p);
		logic [HUE_W-1:0] h;
		pix_t o;
		o = p;
		h = p.neg ? p.base - HUE_W'(p.hq) : p.base + HUE_W'(p.hq);
		if (h > HUE_MAX) h = HUE_MAX;
		if (p.grey) h = '0;
		o.hue = h;
		if (p.mx == '0) o.sq = '0;
		return o;
	endfunction

	function automatic logic [CLS_W-1:0] band_fn(input logic [HUE_W-1:0] h);
		logic [CLS_W-1:0] k;
		if (h >= BAND_RED_WRAP || h < BAND_ORANGE) k = CLS_RED;
		else if (h < BAND_YELLOW) k = CLS_ORANGE;
		else if (h < BAND_LIME) k = CLS_YELLOW;
		else if (h < BAND_GREEN) k = CLS_LIME;
		else if (h < BAND_SPRING) k = CLS_GREEN;
		else if (h < BAND_CYAN) k = CLS_SPRING;
		else if (h < BAND_AZURE) k = CLS_CYAN;
		else if (h < BAND_BLUE) k = CLS_AZURE;
		else if (h < BAND_VIOLET) k = CLS_BLUE;
		else if (h < BAND_MAGENTA) k = CLS_VIOLET;
		else if (h < BAND_PINKRED) k = CLS_MAGENTA;
		else k = CLS_PINKRED;
		return k;
	endfunction

	function automatic pix_t class_fn(input pix_t p);
		pix_t o;
		o = p;
		o.cls = p.grey ? CLS_GREY : band_fn(p.hue);
		return o;
	endfunction

	pix_t pl_s  [NST];
	logic vld_s [NST];
	logic rdy   [NST+1];

	assign rdy[NST] = m_tready;

	for (genvar k = 0; k < NST; k++) begin : g_st
		pix_t nxt;
		logic prev_v;

		if (k == 0) begin : g_front
			assign prev_v = s_tvalid;
			assign nxt = front_fn(s_tdata);
		end else if (k == 1) begin : g_prep
			assign prev_v = vld_s[k-1];
			assign nxt = prep_fn(pl_s[k-1]);
		end else if (k == 2) begin : g_div_recip
			assign prev_v = vld_s[k-1];
			assign nxt = recip_fn(div_step_fn(pl_s[k-1], DIV_BITS - 1 - (k - 2)));
		end else if (k == 3) begin : g_div_fix
			assign prev_v = vld_s[k-1];
			assign nxt = recip_fix_fn(div_step_fn(pl_s[k-1], DIV_BITS - 1 - (k - 2)));
		end else if (k < DIV_BITS + 2) begin : g_div
			assign prev_v = vld_s[k-1];
			assign nxt = div_step_fn(pl_s[k-1], DIV_BITS - 1 - (k - 2));
		end else if (k == NST - 2) begin : g_hue
			assign prev_v = vld_s[k-1];
			assign nxt = hue_fn(pl_s[k-1]);
		end else begin : g_class
			assign prev_v = vld_s[k-1];
			assign nxt = class_fn(pl_s[k-1]);
		end

		// a stage takes a word when it is empty or its word moves on
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				pl_s[k] <= nxt;
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_s[NST-1];
	assign m_tdata  = {{M_PAD_W{1'b0}}, pl_s[NST-1].cq, pl_s[NST-1].vq,
		pl_s[NST-1].sq, pl_s[NST-1].hue};
	assign m_tuser  = {pl_s[NST-1].cls, pl_s[NST-1].grey};

	a_accept_lands : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[0])
		else $error("accepted pixel did not enter the first stage");

	a_grey_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[HUE_W-1:0] == '0 &&
			m_tuser[M_USER_W-1:1] == CLS_GREY &&
			m_tdata[HUE_W+3*PCT_W-1:HUE_W+2*PCT_W] == '0)
		else $error("grey pixel with nonzero hue, class or chroma");

	a_color_class : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[M_USER_W-1:1] != CLS_GREY)
		else $error("colored pixel classed as grey");

	a_ranges : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HUE_W-1:0] <= HUE_MAX &&
			m_tdata[HUE_W+PCT_W-1:HUE_W] <= PCT_MAX &&
			m_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W] <= PCT_MAX &&
			m_tdata[HUE_W+3*PCT_W-1:HUE_W+2*PCT_W] <= PCT_MAX)
		else $error("result field out of range");

endmodule

`default_nettype wire

>>> tb/hsv_result_checker.sv
// result checker for the rgb to hsv hue classifier: predicts each word and compares
`timescale 1ns / 1ps

module hsv_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// red_in, green_in, blue_in
	input  logic [rgbhsv_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// hue_tenths, saturation_tenths, value_tenths, chroma_tenths, zero pad
	input  logic [rgbhsv_pkg::M_DATA_W-1:0]   m_tdata,
	// is_grey, hue_class
	input  logic [rgbhsv_pkg::M_USER_W-1:0]   m_tuser,
	output int                                mismatch_count,
	output int                                outstanding,
	output int                                checked_count,
	output int                                grey_count,
	output logic [12:0]                       classes_seen
);

	import rgbhsv_pkg::*;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] val;
		logic [PCT_W-1:0] chroma;
		logic             grey;
		logic [CLS_W-1:0] cls;
	} hsv_t;

	hsv_t hsv_due_q[$];

	function automatic int round_div(int num, int den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic logic [CLS_W-1:0] hue_band_of(int h);
		if (h >= BAND_RED_WRAP || h < BAND_ORANGE) return CLS_RED;
		else if (h < BAND_YELLOW)  return CLS_ORANGE;
		else if (h < BAND_LIME)    return CLS_YELLOW;
		else if (h < BAND_GREEN)   return CLS_LIME;
		else if (h < BAND_SPRING)  return CLS_GREEN;
		else if (h < BAND_CYAN)    return CLS_SPRING;
		else if (h < BAND_AZURE)   return CLS_CYAN;
		else if (h < BAND_BLUE)    return CLS_AZURE;
		else if (h < BAND_VIOLET)  return CLS_BLUE;
		else if (h < BAND_MAGENTA) return CLS_VIOLET;
		else if (h < BAND_PINKRED) return CLS_MAGENTA;
		else                       return CLS_PINKRED;
	endfunction

	function automatic hsv_t predict_hsv(logic [CH_W-1:0] r8, logic [CH_W-1:0] g8,
			logic [CH_W-1:0] b8);
		int r, g, b, mx, mn, c, h;
		hsv_t res;
		r = r8;
		g = g8;
		b = b8;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		c = mx - mn;
		res.grey = (r == g) && (g == b);
		res.val = PCT_W'(round_div(mx * 1000, 255));
		res.chroma = PCT_W'(round_div(c * 1000, 255));
		res.sat = (mx != 0) ? PCT_W'(round_div(c * 1000, mx)) : '0;
		h = 0;
		res.cls = CLS_GREY;
		if (!res.grey) begin
			// ties go to red, then green
			if (r >= g && r >= b) begin
				if (g >= b)
					h = (600 * (g - b)) / c;
				else
					h = 3600 - (600 * (b - g) + c - 1) / c;
			end else if (g >= b) begin
				h = (1200 * c + 600 * (b - r)) / c;
			end else begin
				h = (2400 * c + 600 * (r - g)) / c;
			end
			if (h > 3599) h = 3599;
			res.cls = hue_band_of(h);
		end
		res.hue = HUE_W'(h);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		hsv_t got;
		int errs;
		if (!arst_n) begin
			hsv_due_q.delete();
			mismatch_count <= 0;
			outstanding <= 0;
			checked_count <= 0;
			grey_count <= 0;
			classes_seen <= '0;
		end else begin
			errs = 0;
			if (s_tvalid && s_tready)
				hsv_due_q.push_back(predict_hsv(s_tdata[0 +: CH_W], s_tdata[CH_W +: CH_W],
					s_tdata[2*CH_W +: CH_W]));
			if (m_tvalid && m_tready) begin
				got.hue = m_tdata[0 +: HUE_W];
				got.sat = m_tdata[HUE_W +: PCT_W];
				got.val = m_tdata[HUE_W+PCT_W +: PCT_W];
				got.chroma = m_tdata[HUE_W+2*PCT_W +: PCT_W];
				got.grey = m_tuser[0];
				got.cls = m_tuser[1 +: CLS_W];
				if (hsv_due_q.size() == 0) begin
					$error("result word with no pixel outstanding: tdata %h tuser %h",
						m_tdata, m_tuser);
					errs++;
				end else begin
					want = hsv_due_q.pop_front();
					if (got.hue !== want.hue) begin
						$error("hue_tenths: expected %0d, actual %0d", want.hue, got.hue);
						errs++;
					end
					if (got.sat !== want.sat) begin
						$error("saturation_tenths: expected %0d, actual %0d", want.sat, got.sat);
						errs++;
					end
					if (got.val !== want.val) begin
						$error("value_tenths: expected %0d, actual %0d", want.val, got.val);
						errs++;
					end
					if (got.chroma !== want.chroma) begin
						$error("chroma_tenths: expected %0d, actual %0d", want.chroma,
							got.chroma);
						errs++;
					end
					if (got.grey !== want.grey) begin
						$error("is_grey: expected %0d, actual %0d", want.grey, got.grey);
						errs++;
					end
					if (got.cls !== want.cls) begin
						$error("hue_class: expected %0d, actual %0d", want.cls, got.cls);
						errs++;
					end
					checked_count <= checked_count + 1;
					if (want.grey) grey_count <= grey_count + 1;
					classes_seen[want.cls] <= 1'b1;
				end
			end
			mismatch_count <= mismatch_count + errs;
			outstanding <= hsv_due_q.size();
		end
	end

endmodule

>>> tb/rgb_to_hsv_hue_classifier_unit_test.sv
// stimulus and verdict for the rgb to hsv hue classifier
`timescale 1ns / 1ps

module rgb_to_hsv_hue_classifier_unit_test;
	import rgbhsv_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	logic                idle_en = 1'b1;
	int                  stall_left = 0;

	int                  mismatch_count;
	int                  outstanding;
	int                  checked_count;
	int                  grey_count;
	logic [12:0]         classes_seen;

	rgb_to_hsv_hue_classifier_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hsv_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.checked_count  (checked_count),
		.grey_count     (grey_count),
		.classes_seen   (classes_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL rgb_to_hsv_hue_classifier_unit");
		$finish;
	end

	// output side stalls in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		logic [CH_W-1:0] r, g, b;
		int i;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white, grey and the tied-max corners
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		// red band wrap: hue just below 3600, and the edges at 75 and 3525
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd8, 8'd1, 8'd0);
		send_pixel(8'd8, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd31, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd0, 8'd255, 8'd128);
		send_pixel(8'd100, 8'd50, 8'd200);
		send_pixel(8'd254, 8'd127, 8'd1);

		for (i = 0; i < 830; i++) begin
			if (i >= 680)
				idle_en <= 1'b0;
			else if (i % 100 == 0)
				idle_en <= ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9))
				0, 1: begin
					// near grey: one channel nudged from a common level
					r = $urandom_range(0, 255);
					g = r;
					b = r;
					case ($urandom_range(0, 2))
						0: r = r ^ CH_W'($urandom_range(0, 3));
						1: g = g ^ CH_W'($urandom_range(0, 3));
						default: b = b ^ CH_W'($urandom_range(0, 3));
					endcase
				end
				2: begin
					// two channels tied
					r = $urandom_range(0, 255);
					g = $urandom_range(0, 255);
					case ($urandom_range(0, 2))
						0: b = r;
						1: b = g;
						default: begin
							b = $urandom_range(0, 255);
							g = b;
						end
					endcase
				end
				3: begin
					r = $urandom_range(0, 15);
					g = $urandom_range(0, 15);
					b = $urandom_range(0, 15);
				end
				default: begin
					r = $urandom_range(0, 255);
					g = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end
			endcase
			send_pixel(r, g, b);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("checked %0d result words, %0d of them grey", checked_count, grey_count);
		$display("hue classes seen (bit per class, grey at bit 0): %b", classes_seen);
		if (mismatch_count == 0)
			$display("PASS rgb_to_hsv_hue_classifier_unit");
		else
			$display("FAIL rgb_to_hsv_hue_classifier_unit");
		$finish;
	end

endmodule
